// File: rtl/lcg_rr_pkg.sv
// ----------------------------------------------------------------------------
// lcg_rr_pkg
// Shared constants and types for the ranged random generator.
// ----------------------------------------------------------------------------
package lcg_rr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SEL_W  = 2;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // generator select codes
  localparam logic [SEL_W-1:0] GEN_A = 2'd0;
  localparam logic [SEL_W-1:0] GEN_B = 2'd1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GEN_SEL = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN     = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX     = 2'd2;

  // lcg constants
  localparam logic [DATA_W-1:0] MUL_A = 32'd8203597;
  localparam logic [DATA_W-1:0] ADD_A = 32'd15;
  localparam logic [DATA_W-1:0] MUL_B = 32'd7563921;
  localparam logic [DATA_W-1:0] ADD_B = 32'd1;

  localparam logic [DATA_W-1:0] MAX_RESET = 32'hFFFF_FFFF;

  // operation codes
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/lcg_rr_step.sv
// ----------------------------------------------------------------------------
// lcg_rr_step
// One linear congruential step, chosen by the generator select code.
// ----------------------------------------------------------------------------
module lcg_rr_step (
  input  logic [lcg_rr_pkg::SEL_W-1:0]  sel,
  input  logic [lcg_rr_pkg::DATA_W-1:0] seed,
  output logic [lcg_rr_pkg::DATA_W-1:0] seed_next
);

  always_comb begin
    unique case (sel)
      lcg_rr_pkg::GEN_A: seed_next = seed * lcg_rr_pkg::MUL_A + lcg_rr_pkg::ADD_A;
      lcg_rr_pkg::GEN_B: seed_next = seed * lcg_rr_pkg::MUL_B + lcg_rr_pkg::ADD_B;
      default:           seed_next = seed;
    endcase
  end

endmodule

// File: rtl/lcg_rr_div.sv
// ----------------------------------------------------------------------------
// lcg_rr_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcg_rr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcg_rr_pkg::div_req_t          req,
  output lcg_rr_pkg::div_stat_t         stat,
  output logic [lcg_rr_pkg::DATA_W-1:0] rem
);

  logic [lcg_rr_pkg::DATA_W-1:0] dvd_r, dvd_nxt;
  logic [lcg_rr_pkg::DATA_W-1:0] dsr_r, dsr_nxt;
  logic [lcg_rr_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [lcg_rr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [lcg_rr_pkg::DATA_W:0]   trial;

  assign trial = {rem_r, dvd_r[lcg_rr_pkg::DATA_W-1]};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[lcg_rr_pkg::DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = lcg_rr_pkg::DATA_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[lcg_rr_pkg::DATA_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {lcg_rr_pkg::CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

// File: rtl/lcg_ranged_random_top.sv
// ----------------------------------------------------------------------------
// lcg_ranged_random_top
// 32-bit linear congruential generator with draws folded into a set range.
// ----------------------------------------------------------------------------
// Each request advances the seed by one generator step (after an optional
// reseed) and returns min plus the new seed modulo the span max+1-min; a zero
// span returns min. A request passes through the step multiply state, then the
// bit-serial remainder unit when the span is non-zero, and then the output
// hand-over state; a zero span skips the remainder unit. A new request is taken
// once the previous result has been moved into the output register, even while
// that result is still waiting to be taken.
// Configuration writes are always accepted and must only be made while idle.
module lcg_ranged_random_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcg_rr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lcg_rr_pkg::DATA_W-1:0] cfg_data,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lcg_rr_pkg::DATA_W-1:0] in_tdata,   // [31:0] new_seed
  input  logic                          in_tuser,   // [0] operation
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lcg_rr_pkg::DATA_W-1:0] out_tdata   // [31:0] value
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [lcg_rr_pkg::SEL_W-1:0]    gen_sel_r;
  logic [lcg_rr_pkg::DATA_W-1:0]   min_r;
  logic [lcg_rr_pkg::DATA_W-1:0]   max_r;
  logic [lcg_rr_pkg::DATA_W-1:0]   seed_r, seed_nxt;
  logic [lcg_rr_pkg::DATA_W-1:0]   res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [lcg_rr_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [lcg_rr_pkg::DATA_W-1:0]   step_seed;
  logic [lcg_rr_pkg::DATA_W-1:0]   span;
  logic [lcg_rr_pkg::DATA_W-1:0]   div_rem;
  lcg_rr_pkg::div_req_t            div_req;
  lcg_rr_pkg::div_stat_t           div_stat;
  logic                            in_acc;

  lcg_rr_step u_step (
    .sel       (gen_sel_r),
    .seed      (seed_r),
    .seed_next (step_seed)
  );

  lcg_rr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .rem   (div_rem)
  );

  assign span      = max_r + 1'b1 - min_r;
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt        = state_r;
    seed_nxt         = seed_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = step_seed;
    div_req.divisor  = span;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == lcg_rr_pkg::OP_RESEED) begin
            seed_nxt = in_tdata;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        seed_nxt = step_seed;
        if (span == '0) begin
          res_nxt   = min_r;
          state_nxt = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_nxt   = div_rem + min_r;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      gen_sel_r   <= lcg_rr_pkg::GEN_A;
      min_r       <= '0;
      max_r       <= lcg_rr_pkg::MAX_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lcg_rr_pkg::REG_GEN_SEL: gen_sel_r <= cfg_data[lcg_rr_pkg::SEL_W-1:0];
          lcg_rr_pkg::REG_MIN:     min_r     <= cfg_data;
          lcg_rr_pkg::REG_MAX:     max_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
